// ===== rtl/lkc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkc_pkg: shared types and constants of the LRU key cache
// Field widths, operation codes and the default table capacity.
// ----------------------------------------------------------------------------
package lkc_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int OPC_W  = 2;
  localparam int KEY_W  = 64;
  localparam int DATA_W = 32;
  localparam int NUM_W  = 5;   // max_entries, evict_count, occupancy, dropped

  typedef logic [OPC_W-1:0]  opcode_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [NUM_W-1:0]  num_t;

  localparam opcode_t OP_LOOKUP = 2'd0;
  localparam opcode_t OP_PUT    = 2'd1;
  localparam opcode_t OP_EVICT  = 2'd2;

  localparam num_t MAX_ENTRIES_RST = 5'd16;

endpackage : lkc_pkg
`default_nettype wire

// ===== rtl/lkc_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkc_in_if: request channel of the LRU key cache
// Valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface lkc_in_if;
  import lkc_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  key_t    key;
  data_t   data_handle;
  num_t    evict_count;

  modport source (output valid, output opcode, output key, output data_handle,
                  output evict_count, input ready);
  modport sink   (input valid, input opcode, input key, input data_handle,
                  input evict_count, output ready);
endinterface : lkc_in_if
`default_nettype wire

// ===== rtl/lkc_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkc_out_if: result channel of the LRU key cache
// Valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface lkc_out_if;
  import lkc_pkg::*;

  logic  valid;
  logic  ready;
  logic  hit;
  data_t data_out;
  num_t  occupancy;
  num_t  dropped;

  modport source (output valid, output hit, output data_out, output occupancy,
                  output dropped, input ready);
  modport sink   (input valid, input hit, input data_out, input occupancy,
                  input dropped, output ready);
endinterface : lkc_out_if
`default_nettype wire

// ===== rtl/lru_key_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_cache: fully associative LRU cache of 64-bit keys to data handles
// Lookup, put/update and evict-oldest over a register-based table.
// ----------------------------------------------------------------------------
// A request word accepted into the input stage register passes on to the result
// register whenever that register is free or is being drained.
// Throughput: one request word per cycle while the result side is not stalled;
// the key compare and rank update over all CAPACITY entries are done between
// the input register and the result register.
// Reset (rst_n low, synchronous): all entries invalid, occupancy zero,
// max_entries back to 16, both channel stages emptied.

module lru_key_cache #(
  parameter int CAPACITY = lkc_pkg::CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  lkc_pkg::num_t        cfg_wdata,
  lkc_in_if.sink               in_ch,
  lkc_out_if.source            out_ch
);
  import lkc_pkg::*;

  // Rank width holds 0 .. CAPACITY-1, count width holds 0 .. CAPACITY.
  localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  // Common width for comparing counts, ranks and the 5-bit register fields,
  // with one bit of headroom for count plus one.
  localparam int WW     = ((CNT_W > NUM_W) ? CNT_W : NUM_W) + 1;

  // Configuration register.
  num_t max_entries_r;

  // Input stage register.
  logic    s1_valid_r, s1_valid_nxt;
  opcode_t s1_op_r;
  key_t    s1_key_r;
  data_t   s1_data_r;
  num_t    s1_cnt_r;

  // Cache table. Keys, data and ranks have no reset: they are only read for
  // entries whose valid bit is set, and those were written first.
  key_t              key_r   [CAPACITY];
  data_t             data_r  [CAPACITY];
  logic [RANK_W-1:0] rank_r  [CAPACITY];
  logic [RANK_W-1:0] rank_nxt[CAPACITY];
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CAPACITY-1:0] key_we, data_we;
  logic [CNT_W-1:0]    count_r, count_nxt;

  // Result register.
  logic  out_valid_r, out_valid_nxt;
  logic  out_hit_r;
  data_t out_data_r;
  num_t  out_occ_r;
  num_t  out_drop_r;

  logic in_acc;
  logic s1_adv;
  logic s1_fire;

  logic          res_hit;
  data_t         res_data;
  logic [WW-1:0] res_drop;

  // The input stage moves on whenever the result register is free or is
  // being drained in this cycle, so a new word can enter every cycle while the result side is not stalled.
  assign s1_adv       = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && s1_adv;
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_acc ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // Main update. Valid ranks always form the set 0 .. count-1, so dropping
  // the n oldest entries is the same as clearing every entry whose rank is at
  // or above count-n, which is done in one pass here.
  always_comb begin
    logic [WW-1:0]       limit_w;
    logic [WW-1:0]       count_w;
    logic [WW-1:0]       evict_w;
    logic [WW-1:0]       ins_cnt;
    logic [WW-1:0]       fin_cnt;
    logic [WW-1:0]       ev_cnt;
    logic [WW-1:0]       ev_thr;
    logic                enabled;
    logic                full;
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] oldest_oh;
    logic [CAPACITY-1:0] free_oh;
    logic [CAPACITY-1:0] inv;
    logic                hit_any;
    logic [RANK_W-1:0]   hit_rank;
    data_t               hit_data;

    limit_w = (WW'(max_entries_r) > WW'(CAPACITY)) ? WW'(CAPACITY)
                                                    : WW'(max_entries_r);
    enabled = (limit_w != '0);
    count_w = WW'(count_r);
    evict_w = WW'(s1_cnt_r);
    full    = (count_w == WW'(CAPACITY));

    hit_rank = '0;
    hit_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]     = valid_r[i] && (key_r[i] == s1_key_r);
      oldest_oh[i] = valid_r[i] && (WW'(rank_r[i]) == (count_w - WW'(1)));
      hit_rank     = hit_rank | (match[i] ? rank_r[i] : '0);
      hit_data     = hit_data | (match[i] ? data_r[i] : '0);
    end
    hit_any = |match;

    // A new entry goes to the lowest free slot; on a full table it reuses
    // the slot of the oldest entry, which is dropped to make room.
    inv     = ~valid_r;
    free_oh = full ? oldest_oh : (inv & (valid_r + CAPACITY'(1)));

    ins_cnt = count_w + WW'(1);
    fin_cnt = (ins_cnt < limit_w) ? ins_cnt : limit_w;
    ev_cnt  = (evict_w < count_w) ? evict_w : count_w;
    ev_thr  = count_w - ev_cnt;

    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    count_nxt = count_r;
    key_we    = '0;
    data_we   = '0;
    res_hit   = 1'b0;
    res_data  = '0;
    res_drop  = '0;

    if (s1_fire && enabled) begin
      case (s1_op_r)
        OP_LOOKUP, OP_PUT: begin
          if (hit_any) begin
            // Promote the hit entry; those that were more recent age by one.
            res_hit = 1'b1;
            for (int i = 0; i < CAPACITY; i++) begin
              if (match[i]) begin
                rank_nxt[i] = '0;
              end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
                rank_nxt[i] = rank_r[i] + RANK_W'(1);
              end
            end
            if (s1_op_r == OP_PUT) begin
              data_we  = match;
              res_data = s1_data_r;
            end else begin
              res_data = hit_data;
            end
          end else if (s1_op_r == OP_PUT) begin
            // Insert at rank zero, age everything else, then trim to the limit.
            for (int i = 0; i < CAPACITY; i++) begin
              if (free_oh[i]) begin
                valid_nxt[i] = 1'b1;
                rank_nxt[i]  = '0;
              end else if (valid_r[i]) begin
                rank_nxt[i]  = rank_r[i] + RANK_W'(1);
                valid_nxt[i] = ((WW'(rank_r[i]) + WW'(1)) < fin_cnt);
              end
            end
            key_we    = free_oh;
            data_we   = free_oh;
            count_nxt = CNT_W'(fin_cnt);
            res_drop  = ins_cnt - fin_cnt;
          end
        end
        OP_EVICT: begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (valid_r[i] && (WW'(rank_r[i]) >= ev_thr)) begin
              valid_nxt[i] = 1'b0;
            end
          end
          count_nxt = CNT_W'(ev_thr);
          res_drop  = ev_cnt;
        end
        default: begin
          // Unused code: no change, empty result.
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= MAX_ENTRIES_RST;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      valid_r       <= '0;
      count_r       <= '0;
    end else begin
      if (cfg_we) begin
        max_entries_r <= cfg_wdata;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // Payload registers and table contents.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_ch.opcode;
      s1_key_r  <= in_ch.key;
      s1_data_r <= in_ch.data_handle;
      s1_cnt_r  <= in_ch.evict_count;
    end
    if (s1_fire) begin
      out_hit_r  <= res_hit;
      out_data_r <= res_data;
      out_occ_r  <= NUM_W'(count_nxt);
      out_drop_r <= NUM_W'(res_drop);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      rank_r[i] <= rank_nxt[i];
      if (key_we[i]) begin
        key_r[i] <= s1_key_r;
      end
      if (data_we[i]) begin
        data_r[i] <= s1_data_r;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hit       = out_hit_r;
  assign out_ch.data_out  = out_data_r;
  assign out_ch.occupancy = out_occ_r;
  assign out_ch.dropped   = out_drop_r;

endmodule : lru_key_cache
`default_nettype wire

// ===== rtl/lkc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkc_checker: port-level assertions for the LRU key cache
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module lkc_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire logic          out_hit,
  input wire lkc_pkg::data_t out_data_out,
  input wire lkc_pkg::num_t out_occupancy,
  input wire lkc_pkg::num_t out_dropped
);
  import lkc_pkg::*;

  // A result word that is stalled holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit)
      && $stable(out_data_out) && $stable(out_occupancy) && $stable(out_dropped))
    else $error("stalled result word changed");

  // A miss never carries a data handle.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_data_out == '0)
    else $error("miss returned nonzero data");

  // A hit never drops entries.
  a_hit_nodrop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_dropped == '0)
    else $error("hit reported dropped entries");

  // With the result side draining while the word is in the input stage, an accepted word shows up as a result word.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("result word missing after accepted request");

endmodule : lkc_checker

bind lru_key_cache lkc_checker u_lkc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_hit       (out_ch.hit),
  .out_data_out  (out_ch.data_out),
  .out_occupancy (out_ch.occupancy),
  .out_dropped   (out_ch.dropped)
);
`default_nettype wire
